### hw/rtl/assert_macros.svh
// Assertion macros shared by the status record parser RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASRP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
`define ASRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");
`else
`define ASRP_ASSERT(lbl, clk, rst_n, prop)
`define ASRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/asrp_pkg.sv
// Types and constants of the aux status record parser.
// Used by every module of the block but asrp_ram; depends on nothing.
`default_nettype none

package asrp_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] device_number;
		logic [7:0] stored_idx;
		logic       is_on;
		logic [7:0] device_type;
		logic [7:0] name_length;
		logic [7:0] name_char;
		logic [2:0] status;
		logic       last;
	} res_item_t;

	// Results caused by one item: count and up to two slots, oldest in slot 0
	typedef struct packed {
		logic [1:0]            n;
		res_item_t [1:0]       r;
	} res_pair_t;

	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_PAYLOAD  = 3'd1;
	localparam logic [2:0] ST_SHORT_INDEX = 3'd2;
	localparam logic [2:0] ST_SHORT_HDR   = 3'd3;
	localparam logic [2:0] ST_SHORT_NAME  = 3'd4;

	localparam logic       REG_HEADER_LENGTH = 1'b0;
	localparam logic       REG_FOOTER_LENGTH = 1'b1;
	localparam logic [3:0] HEADER_LENGTH_RST = 4'd4;
	localparam logic [2:0] FOOTER_LENGTH_RST = 3'd3;

	localparam logic [7:0] STATUS_ON_BYTE = 8'h01;
	localparam logic [7:0] REC_HDR_BYTES  = 8'd5;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

endpackage

`default_nettype wire

### hw/rtl/aux_status_record_parser.sv
// Top level of the aux status record parser: config registers, index store,
// result stage and queue. Depends on asrp_pkg, asrp_parse, asrp_ram, asrp_outq and assert_macros.svh.
//
// Use: message bytes enter on msg_valid/msg_ready/msg_item, one item per byte,
// end_of_message set on the final byte. Results leave on res_valid/res_ready/
// res_item: name characters, device records and one done result per message
// (or a record carrying last and the status when the final byte closes it).
// header_length and footer_length sit at byte addresses 0 and 4 of the APB
// port; write them only while the block is idle.
// Path: the results of a taken item are registered in the merge stage (parse and
// store read), then merged into the queue, where a result waits behind those
// queued before it until it shows on res_item.
// Throughput: one item a cycle while the receiver keeps up; an item that ends
// a name gives two results, which leave one per handshake. msg_ready drops
// while the queue and the merge stage together could not take two more
// results, so a stalled receiver holds the input back after a few items.
// Reset: registers go to header 4 and footer 3, the parser to header skip,
// the queue empties. The index store is not cleared: each entry is written by
// the message that reads it, so no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module aux_status_record_parser import asrp_pkg::*; #(
	parameter int MAX_DEVICES = 256,
	parameter int MAX_FOOTER  = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_ready,
	input  wire msg_item_t   msg_item,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_item_t        res_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

	logic [3:0]         hdr_len_q;
	logic [2:0]         ftr_len_q;
	logic               msg_acc;
	res_pair_t          pair;
	logic               idx_we;
	logic [AW-1:0]      idx_waddr;
	logic [7:0]         idx_wdata;
	logic [AW-1:0]      idx_raddr;
	logic               idx_rd_ok;
	logic [7:0]         idx_rdata;
	logic               valid_s1;
	res_pair_t          pair_s1;
	logic               rd_ok_s1;
	res_item_t [1:0]    merged;
	logic [1:0]         push_n;
	logic [OUTQ_CW-1:0] q_count;
	logic [OUTQ_CW:0]   q_load;

	// Configuration port: writes land in the access phase, pready stays high
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_len_q <= HEADER_LENGTH_RST;
			ftr_len_q <= FOOTER_LENGTH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HEADER_LENGTH: hdr_len_q <= pwdata[3:0];
				REG_FOOTER_LENGTH: ftr_len_q <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HEADER_LENGTH: prdata = {28'd0, hdr_len_q};
			REG_FOOTER_LENGTH: prdata = {29'd0, ftr_len_q};
			default:           prdata = '0;
		endcase
	end

	// Take an item only when the queue plus the merge stage leaves two free slots
	assign q_load    = {1'b0, q_count} + (OUTQ_CW + 1)'(push_n);
	assign msg_ready = (q_load <= (OUTQ_CW + 1)'(OUTQ_DEPTH - 2));
	assign msg_acc   = msg_valid && msg_ready;

	asrp_parse #(
		.MAX_DEVICES (MAX_DEVICES),
		.MAX_FOOTER  (MAX_FOOTER),
		.AW          (AW)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (msg_acc),
		.item          (msg_item),
		.header_length (hdr_len_q),
		.footer_length (ftr_len_q),
		.res           (pair),
		.idx_we        (idx_we),
		.idx_waddr     (idx_waddr),
		.idx_wdata     (idx_wdata),
		.idx_raddr     (idx_raddr),
		.idx_rd_ok     (idx_rd_ok)
	);

	// Index store: written during the index list, read once per item. Records
	// start at least five bytes after the last index write, so no forwarding.
	asrp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_DEVICES),
		.AW    (AW)
	) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.re    (msg_acc),
		.raddr (idx_raddr),
		.rdata (idx_rdata)
	);

	// Merge stage: hold the results in registers until the stored index returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= msg_acc;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1  <= pair;
		rd_ok_s1 <= idx_rd_ok;
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			merged[k] = pair_s1.r[k];
			if (pair_s1.r[k].kind != KIND_DONE && rd_ok_s1) begin
				merged[k].stored_idx = idx_rdata;
			end
		end
	end

	assign push_n = valid_s1 ? pair_s1.n : 2'd0;

	asrp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_items (merged),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.count      (q_count)
	);

	`ASRP_ASSERT(a_queue_room, clk, arst_n, (q_load <= (OUTQ_CW + 1)'(OUTQ_DEPTH)))
	`ASRP_ASSERT(a_eom_result, clk, arst_n, (msg_acc && msg_item.end_of_message |=> valid_s1 && pair_s1.n != 2'd0))
	`ASRP_ASSERT_IMPL(a_done_clean, clk, arst_n, res_valid && res_item.kind == KIND_DONE, res_item.last && res_item.stored_idx == 8'd0)
	`ASRP_ASSERT_IMPL(a_pair_order, clk, arst_n, valid_s1 && pair_s1.n == 2'd2, pair_s1.r[0].kind != KIND_DONE && pair_s1.r[1].kind != KIND_CHAR)

endmodule

`default_nettype wire

### hw/rtl/asrp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module asrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/asrp_parse.sv
// Byte-level message parser: header skip, footer delay line, record decode.
// Depends on asrp_pkg; drives the write and read ports of the index store.
`default_nettype none

module asrp_parse import asrp_pkg::*; #(
	parameter int MAX_DEVICES = 256,
	parameter int MAX_FOOTER  = 7,
	parameter int AW          = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire msg_item_t     item,
	input  wire logic [3:0]    header_length,
	input  wire logic [2:0]    footer_length,
	output res_pair_t          res,
	output logic               idx_we,
	output logic [AW-1:0]      idx_waddr,
	output logic [7:0]         idx_wdata,
	output logic [AW-1:0]      idx_raddr,
	output logic               idx_rd_ok
);

	localparam int FW = $clog2(MAX_FOOTER + 1);
	localparam int CW = (FW > 3) ? FW : 3;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_COUNT   = 6'b000010,
		PH_INDICES = 6'b000100,
		PH_RECHDR  = 6'b001000,
		PH_NAME    = 6'b010000,
		PH_TRAIL   = 6'b100000
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [7:0]    cnt_q, cnt_d;
	logic [7:0]    dly_q [MAX_FOOTER];
	logic [7:0]    dly_d [MAX_FOOTER];
	logic [FW-1:0] fill_q, fill_d;
	logic [7:0]    total_q, total_d;
	logic [7:0]    ord_q, ord_d;
	logic          on_q, on_d;
	logic [7:0]    type_q, type_d;
	logic [7:0]    rem_q, rem_d;
	logic [7:0]    ntot_q, ntot_d;

	always_comb begin
		logic [CW-1:0] fl_ext;
		logic [CW-1:0] fl_eff;
		logic          parse_en;
		logic [7:0]    pb;
		logic [7:0]    c1;
		logic [7:0]    o1;
		logic [2:0]    st;
		res_item_t     rec;
		res_item_t     done;

		phase_d = phase_q;
		cnt_d   = cnt_q;
		dly_d   = dly_q;
		fill_d  = fill_q;
		total_d = total_q;
		ord_d   = ord_q;
		on_d    = on_q;
		type_d  = type_q;
		rem_d   = rem_q;
		ntot_d  = ntot_q;
		res     = '0;
		idx_we    = 1'b0;
		idx_waddr = '0;
		idx_wdata = '0;
		parse_en  = 1'b0;
		pb        = '0;
		c1        = '0;
		o1        = '0;
		st        = ST_NO_PAYLOAD;
		rec       = '0;
		done      = '0;

		fl_ext = CW'(footer_length);
		fl_eff = (fl_ext > CW'(MAX_FOOTER)) ? CW'(MAX_FOOTER) : fl_ext;

		if (accept) begin
			if (phase_q == PH_HEADER && cnt_q < {4'b0000, header_length}) begin
				cnt_d = cnt_q + 8'd1;
			end else begin
				if (phase_q == PH_HEADER) begin
					phase_d = PH_COUNT;
					cnt_d   = '0;
				end
				// fill the delay line first, then release the oldest byte per byte
				if (CW'(fill_q) < fl_eff) begin
					for (int i = 0; i < MAX_FOOTER; i++) begin
						if (int'(fill_q) == i) begin
							dly_d[i] = item.msg_byte;
						end
					end
					fill_d = fill_q + FW'(1);
				end else if (fill_q == '0) begin
					parse_en = 1'b1;
					pb       = item.msg_byte;
				end else begin
					parse_en = 1'b1;
					pb       = dly_q[0];
					for (int i = 0; i < MAX_FOOTER - 1; i++) begin
						if (i + 1 < int'(fill_q)) begin
							dly_d[i] = dly_q[i + 1];
						end
					end
					for (int i = 0; i < MAX_FOOTER; i++) begin
						if (i + 1 == int'(fill_q)) begin
							dly_d[i] = item.msg_byte;
						end
					end
				end
			end

			if (parse_en) begin
				c1 = cnt_d + 8'd1;
				unique case (phase_d)
					PH_COUNT: begin
						total_d = pb;
						ord_d   = '0;
						cnt_d   = '0;
						phase_d = (pb == 8'd0) ? PH_TRAIL : PH_INDICES;
					end
					PH_INDICES: begin
						idx_we    = ({1'b0, cnt_d} < 9'(MAX_DEVICES));
						idx_waddr = cnt_d[AW-1:0];
						idx_wdata = pb;
						if (c1 >= total_d) begin
							cnt_d   = '0;
							ord_d   = '0;
							phase_d = PH_RECHDR;
						end else begin
							cnt_d = c1;
						end
					end
					PH_RECHDR: begin
						if (cnt_d == 8'd0) begin
							on_d = (pb == STATUS_ON_BYTE);
						end
						if (cnt_d == 8'd1) begin
							type_d = pb;
						end
						if (c1 >= REC_HDR_BYTES) begin
							ntot_d = pb;
							rem_d  = pb;
							cnt_d  = '0;
							if (pb == 8'd0) begin
								rec.kind          = KIND_RECORD;
								rec.device_number = ord_q;
								rec.is_on         = on_d;
								rec.device_type   = type_d;
								rec.name_length   = pb;
								res.r[0] = rec;
								res.n    = 2'd1;
								o1       = ord_q + 8'd1;
								ord_d    = o1;
								phase_d  = (o1 >= total_d) ? PH_TRAIL : PH_RECHDR;
							end else begin
								phase_d = PH_NAME;
							end
						end else begin
							cnt_d = c1;
						end
					end
					PH_NAME: begin
						rec.kind          = KIND_CHAR;
						rec.device_number = ord_q;
						rec.is_on         = on_q;
						rec.device_type   = type_q;
						rec.name_length   = ntot_q;
						rec.name_char     = pb;
						res.r[0] = rec;
						res.n    = 2'd1;
						rem_d    = rem_q - 8'd1;
						if (rem_d == 8'd0) begin
							rec.kind      = KIND_RECORD;
							rec.name_char = '0;
							res.r[1] = rec;
							res.n    = 2'd2;
							o1       = ord_q + 8'd1;
							ord_d    = o1;
							cnt_d    = '0;
							phase_d  = (o1 >= total_d) ? PH_TRAIL : PH_RECHDR;
						end
					end
					default: begin
					end
				endcase
			end

			if (item.end_of_message) begin
				unique case (phase_d)
					PH_INDICES: st = ST_SHORT_INDEX;
					PH_RECHDR:  st = ST_SHORT_HDR;
					PH_NAME:    st = ST_SHORT_NAME;
					PH_TRAIL:   st = ST_OK;
					default:    st = ST_NO_PAYLOAD;
				endcase
				if (res.n == 2'd2) begin
					// fold the done status into the record result
					res.r[1].status = st;
					res.r[1].last   = 1'b1;
				end else begin
					done.kind          = KIND_DONE;
					done.device_number = ord_d;
					done.status        = st;
					done.last          = 1'b1;
					if (res.n == 2'd0) begin
						res.r[0] = done;
					end else begin
						res.r[1] = done;
					end
					res.n = res.n + 2'd1;
				end
				phase_d = PH_HEADER;
				cnt_d   = '0;
				fill_d  = '0;
				total_d = '0;
				ord_d   = '0;
				on_d    = 1'b0;
				type_d  = '0;
				rem_d   = '0;
				ntot_d  = '0;
			end
		end
	end

	// one read per item, at the ordinal the results of that item carry
	assign idx_raddr = ord_q[AW-1:0];
	assign idx_rd_ok = ({1'b0, ord_q} < 9'(MAX_DEVICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
			ord_q   <= '0;
			on_q    <= 1'b0;
			type_q  <= '0;
			rem_q   <= '0;
			ntot_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fill_q  <= fill_d;
			total_q <= total_d;
			ord_q   <= ord_d;
			on_q    <= on_d;
			type_q  <= type_d;
			rem_q   <= rem_d;
			ntot_q  <= ntot_d;
		end
	end

	always_ff @(posedge clk) begin
		dly_q <= dly_d;
	end

endmodule

`default_nettype wire

### hw/rtl/asrp_outq.sv
// Result queue: takes up to two results a cycle, hands out one per handshake.
// Depends on asrp_pkg.
`default_nettype none

module asrp_outq import asrp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_n,
	input  wire res_item_t [1:0]    push_items,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output res_item_t               res_item,
	output logic [OUTQ_CW-1:0]      count
);

	res_item_t          q_q [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0] wp_q, rp_q;
	logic [OUTQ_CW-1:0] cnt_q;
	logic               pop;
	logic [OUTQ_PW-1:0] wp1;

	assign res_valid = (cnt_q != '0);
	assign res_item  = q_q[rp_q];
	assign pop       = res_valid && res_ready;
	assign count     = cnt_q;
	assign wp1       = wp_q + OUTQ_PW'(1);

	always_ff @(posedge clk) begin
		for (int i = 0; i < OUTQ_DEPTH; i++) begin
			if (push_n != 2'd0 && wp_q == OUTQ_PW'(i)) begin
				q_q[i] <= push_items[0];
			end
			if (push_n == 2'd2 && wp1 == OUTQ_PW'(i)) begin
				q_q[i] <= push_items[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PW'(push_n);
			rp_q  <= rp_q + OUTQ_PW'(pop);
			cnt_q <= cnt_q + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
		end
	end

endmodule

`default_nettype wire

### test/aux_status_record_parser_test.sv
// Testbench of aux_status_record_parser: message bytes in, results out, APB register writes.
// A parsing predictor of its own queues the expected results, which are checked in order.
// Depends on asrp_pkg and the RTL of the block.
`timescale 1ns / 1ps

import asrp_pkg::*;

typedef enum logic [5:0] {
	P_HEADER  = 6'b000001,
	P_COUNT   = 6'b000010,
	P_INDICES = 6'b000100,
	P_RECHDR  = 6'b001000,
	P_NAME    = 6'b010000,
	P_TRAIL   = 6'b100000
} parse_phase_t;

class record_parse_checker;
	logic [3:0]   hdr_len;
	logic [2:0]   ftr_len;
	parse_phase_t phase;
	logic [7:0]   byte_cnt;
	logic [7:0]   delay_line [7];
	int           fill;
	logic [7:0]   dev_total;
	logic [7:0]   dev_ord;
	logic [7:0]   index_mem [256];
	logic         rec_on;
	logic [7:0]   rec_type;
	logic [7:0]   name_left;
	logic [7:0]   name_bytes;
	res_item_t    step_results[$];
	res_item_t    pending_results[$];
	int           mismatches;

	function new();
		hdr_len = HEADER_LENGTH_RST;
		ftr_len = FOOTER_LENGTH_RST;
		mismatches = 0;
		restart();
	endfunction

	function void restart();
		phase = P_HEADER;
		byte_cnt = '0;
		fill = 0;
		dev_total = '0;
		dev_ord = '0;
		rec_on = 1'b0;
		rec_type = '0;
		name_left = '0;
		name_bytes = '0;
	endfunction

	function void set_register(logic idx, logic [31:0] value);
		if (idx == REG_HEADER_LENGTH) begin
			hdr_len = value[3:0];
		end else begin
			ftr_len = value[2:0];
		end
	endfunction

	function res_item_t device_result(logic [1:0] kind, logic [7:0] ch);
		res_item_t r;
		r = '0;
		r.kind = kind;
		r.device_number = dev_ord;
		r.stored_idx = index_mem[dev_ord];
		r.is_on = rec_on;
		r.device_type = rec_type;
		r.name_length = name_bytes;
		r.name_char = ch;
		return r;
	endfunction

	function void next_device();
		dev_ord = dev_ord + 8'd1;
		byte_cnt = '0;
		phase = (dev_ord >= dev_total) ? P_TRAIL : P_RECHDR;
	endfunction

	// One payload byte, released from the footer delay line
	function void parse_byte(logic [7:0] b);
		case (phase)
			P_COUNT: begin
				dev_total = b;
				dev_ord = '0;
				byte_cnt = '0;
				phase = (b == 8'd0) ? P_TRAIL : P_INDICES;
			end
			P_INDICES: begin
				index_mem[byte_cnt] = b;
				byte_cnt = byte_cnt + 8'd1;
				if (byte_cnt >= dev_total) begin
					byte_cnt = '0;
					dev_ord = '0;
					phase = P_RECHDR;
				end
			end
			P_RECHDR: begin
				if (byte_cnt == 8'd0) begin
					rec_on = (b == STATUS_ON_BYTE);
				end else if (byte_cnt == 8'd1) begin
					rec_type = b;
				end
				byte_cnt = byte_cnt + 8'd1;
				if (byte_cnt >= REC_HDR_BYTES) begin
					name_bytes = b;
					name_left = b;
					byte_cnt = '0;
					if (b == 8'd0) begin
						step_results = {step_results, device_result(KIND_RECORD, 8'd0)};
						next_device();
					end else begin
						phase = P_NAME;
					end
				end
			end
			P_NAME: begin
				step_results = {step_results, device_result(KIND_CHAR, b)};
				name_left = name_left - 8'd1;
				if (name_left == 8'd0) begin
					step_results = {step_results, device_result(KIND_RECORD, 8'd0)};
					next_device();
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Note an accepted input item and queue what it must produce
	function void take_byte(msg_item_t it);
		res_item_t  r;
		logic [2:0] st;
		logic [7:0] rel;
		step_results.delete();
		if (phase == P_HEADER && byte_cnt < hdr_len) begin
			byte_cnt = byte_cnt + 8'd1;
		end else begin
			if (phase == P_HEADER) begin
				phase = P_COUNT;
				byte_cnt = '0;
			end
			if (fill < int'(ftr_len)) begin
				delay_line[fill] = it.msg_byte;
				fill++;
			end else if (fill == 0) begin
				parse_byte(it.msg_byte);
			end else begin
				rel = delay_line[0];
				for (int i = 0; i < fill - 1; i++) delay_line[i] = delay_line[i + 1];
				delay_line[fill - 1] = it.msg_byte;
				parse_byte(rel);
			end
		end
		if (it.end_of_message) begin
			case (phase)
				P_INDICES: st = ST_SHORT_INDEX;
				P_RECHDR:  st = ST_SHORT_HDR;
				P_NAME:    st = ST_SHORT_NAME;
				P_TRAIL:   st = ST_OK;
				default:   st = ST_NO_PAYLOAD;
			endcase
			if (step_results.size() == 2) begin
				// closing byte finished a name: the record carries the status
				r = step_results[1];
				r.status = st;
				r.last = 1'b1;
				step_results[1] = r;
			end else begin
				r = '0;
				r.kind = KIND_DONE;
				r.device_number = dev_ord;
				r.status = st;
				r.last = 1'b1;
				step_results = {step_results, r};
			end
			restart();
		end
		pending_results = {pending_results, step_results};
	endfunction

	function string show(res_item_t r);
		return $sformatf("kind=%0d dev=%0d idx=%02h on=%0d type=%02h len=%0d ch=%02h st=%0d last=%0d",
			r.kind, r.device_number, r.stored_idx, r.is_on, r.device_type,
			r.name_length, r.name_char, r.status, r.last);
	endfunction

	function void check_result(res_item_t got);
		res_item_t want;
		string     diff;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result: %s", show(got));
			return;
		end
		want = pending_results.pop_front();
		diff = "";
		if (got.kind != want.kind) diff = {diff, " kind"};
		if (got.device_number != want.device_number) diff = {diff, " device_number"};
		if (got.stored_idx != want.stored_idx) diff = {diff, " stored_idx"};
		if (got.is_on != want.is_on) diff = {diff, " is_on"};
		if (got.device_type != want.device_type) diff = {diff, " device_type"};
		if (got.name_length != want.name_length) diff = {diff, " name_length"};
		if (got.name_char != want.name_char) diff = {diff, " name_char"};
		if (got.status != want.status) diff = {diff, " status"};
		if (got.last != want.last) diff = {diff, " last"};
		if (diff != "") begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch in%s\n  expected %s\n  actual   %s", diff, show(want), show(got));
			end
		end
	endfunction
endclass

module aux_status_record_parser_test;
	localparam int STALL_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 115;
	localparam int CONFIG_SETS  = 8;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	msg_item_t   msg_item = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_item_t   res_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	record_parse_checker sb = new();
	int items_sent = 0;
	int sender_idle_pct;
	int receiver_idle_pct;

	aux_status_record_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_item  (msg_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idling schedule follows progress through the stimulus: sender idles lightly and the
	// receiver heavily, then the other way round, then neither side idles at all.
	always_comb begin
		if (items_sent < 350) begin
			sender_idle_pct = 15;
			receiver_idle_pct = 52;
		end else if (items_sent < 700) begin
			sender_idle_pct = 52;
			receiver_idle_pct = 15;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
	end

	// Stall the result side at random; the value is registered, so it holds between edges
	always @(posedge clk) begin
		res_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	// Check every result taken at this edge against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.check_result(res_item);
		end
	end

	// Watchdog: end the run when nothing has moved for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((msg_valid && msg_ready) || (res_valid && res_ready) || psel || !arst_n) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("Some tests failed");
		$finish;
	end

	// Register write: setup cycle, then access cycle; the write lands at the access edge
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one item, maybe after a random gap, and hold it until it is taken
	task automatic put_byte(input msg_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_item <= it;
		@(posedge clk);
		while (!msg_ready) @(posedge clk);
		items_sent++;
		sb.take_byte(it);
	endtask

	task automatic send_message(input logic [7:0] bytes[$]);
		msg_item_t it;
		foreach (bytes[i]) begin
			it.msg_byte = bytes[i];
			it.end_of_message = (i == bytes.size() - 1);
			put_byte(it);
		end
	endtask

	// Drop valid and wait until every result is in, then let the pipeline settle
	task automatic drain();
		msg_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Build one message for the current register setting. Most are well formed with random
	// content; some are cut short, a few are plain noise.
	task automatic build_message(output logic [7:0] bytes[$]);
		int  pick;
		int  cut;
		int  n_dev;
		int  n_name;
		bit  big;
		bytes.delete();
		big = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 12)) bytes = {bytes, 8'($urandom)};
			return;
		end
		repeat (sb.hdr_len) bytes = {bytes, 8'($urandom)};
		case ($urandom_range(0, 9))
			0: n_dev = 0;
			9: begin
				n_dev = $urandom_range(5, 255);
				big = (n_dev > 12);
			end
			default: n_dev = $urandom_range(1, 4);
		endcase
		bytes = {bytes, 8'(n_dev)};
		repeat (n_dev) bytes = {bytes, 8'($urandom)};
		for (int d = 0; d < n_dev && bytes.size() < 200; d++) begin
			bytes = {bytes, ($urandom_range(0, 1) ? STATUS_ON_BYTE : 8'($urandom))};
			bytes = {bytes, 8'($urandom)};
			bytes = {bytes, 8'($urandom)};
			bytes = {bytes, 8'($urandom)};
			if ($urandom_range(0, 19) == 0) begin
				n_name = $urandom_range(6, 255);
				big = big || (n_name > 20);
			end else begin
				n_name = $urandom_range(0, 5);
			end
			bytes = {bytes, 8'(n_name)};
			repeat (n_name) bytes = {bytes, 8'($urandom)};
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) bytes = {bytes, 8'($urandom)};
		end
		repeat (sb.ftr_len) bytes = {bytes, 8'($urandom)};
		// keep long declared lengths cheap: cut them off early
		if (big) begin
			cut = $urandom_range(1, sb.hdr_len + 40);
			while (bytes.size() > cut) void'(bytes.pop_back());
		end else if (pick < 25) begin
			cut = $urandom_range(1, bytes.size());
			while (bytes.size() > cut) void'(bytes.pop_back());
		end
	endtask

	initial begin
		logic [7:0]  bytes[$];
		logic [3:0]  hdr;
		logic [2:0]  ftr;
		logic [31:0] value;
		int          phase_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset setting (header 4, footer 3): lone byte gives no payload,
		// then one device with a one-byte name
		bytes = '{8'hFF};
		send_message(bytes);
		bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hAB, 8'h01, 8'h7E,
			8'h00, 8'hFF, 8'h01, 8'h5A, 8'h00, 8'h00, 8'h00};
		send_message(bytes);
		drain();

		// No header and no footer: zero devices, then a name ending on the closing byte
		write_reg(REG_HEADER_LENGTH, 32'd0);
		write_reg(REG_FOOTER_LENGTH, 32'd0);
		bytes = '{8'h00};
		send_message(bytes);
		bytes = '{8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h41};
		send_message(bytes);
		drain();

		// Random messages over several register settings, extremes first
		for (int ph = 0; ph < CONFIG_SETS; ph++) begin
			case (ph)
				0: begin
					hdr = 4'd15;
					ftr = 3'd7;
				end
				1: begin
					hdr = 4'd0;
					ftr = 3'd7;
				end
				2: begin
					hdr = 4'd15;
					ftr = 3'd0;
				end
				default: begin
					hdr = 4'($urandom_range(0, 15));
					ftr = 3'($urandom_range(0, 7));
				end
			endcase
			// upper bits of the write data are don't-care
			value = $urandom;
			value[3:0] = hdr;
			write_reg(REG_HEADER_LENGTH, value);
			value = $urandom;
			value[2:0] = ftr;
			write_reg(REG_FOOTER_LENGTH, value);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				build_message(bytes);
				send_message(bytes);
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### aux_status_record_parser.f
+incdir+hw/rtl
hw/rtl/asrp_pkg.sv
hw/rtl/asrp_ram.sv
hw/rtl/asrp_parse.sv
hw/rtl/asrp_outq.sv
hw/rtl/aux_status_record_parser.sv
test/aux_status_record_parser_test.sv
